// ===== rtl/dsii_pkg.sv =====
`timescale 1ns / 1ps

package dsii_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_SHRD  = 4'b0100,
        S_SHWR  = 4'b1000
    } state_t;

endpackage

// ===== rtl/data_stack_with_indexed_insert_top.sv =====
`timescale 1ns / 1ps

// channel | handshake          | payload
// s_      | s_valid / s_ready  | s_action, s_value_in, s_position
// m_      | m_valid / m_ready  | m_value_out, m_status, m_fill_count
//
// push, errors and unknown actions: result in the cycle after the beat
// pop, peek, read: result after the S_FETCH state (one registered read of the element memory)
// insert: S_SHRD / S_SHWR loop, remove: S_FETCH, then the S_SHRD / S_SHWR loop;
//   one memory read and one write per moved element through the single port pair
// synchronous active-low reset clears the count
// s_ready is low while an item is in work or its result waits on m_ready

module data_stack_with_indexed_insert_top
    import dsii_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ACTION_W-1:0]           s_action,
    input  logic signed [DATA_WIDTH-1:0]  s_value_in,
    input  logic [$clog2(DEPTH+1)-1:0]    s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]  m_value_out,
    output logic [STATUS_W-1:0]           m_status,
    output logic [$clog2(DEPTH+1)-1:0]    m_fill_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [ACTION_W-1:0]   act_reg, act_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] m_value_reg, m_value_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;

    logic                  s_fire;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         idx_dec;

    assign s_ready      = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_fire       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_value_out  = m_value_reg;
    assign m_status     = m_status_reg;
    assign m_fill_count = count_reg;
    assign idx_inc      = idx_reg + ONE_C;
    assign idx_dec      = idx_reg - ONE_C;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        act_next      = act_reg;
        word_next     = word_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[AW-1:0];
        mem_wdata     = rd_data_reg;
        mem_raddr     = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    act_next      = s_action;
                    word_next     = s_value_in;
                    pos_next      = s_position;
                    m_value_next  = '0;
                    m_status_next = ST_OK;
                    unique case (s_action)
                        ACT_PUSH: begin
                            if (count_reg == DEPTH_C) begin
                                m_status_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = s_value_in;
                                count_next = count_reg + ONE_C;
                            end
                            m_valid_next = 1'b1;
                        end
                        ACT_POP, ACT_PEEK: begin
                            if (count_reg == '0) begin
                                m_status_next = ST_EMPTY;
                                m_valid_next  = 1'b1;
                            end else begin
                                mem_raddr  = AW'(count_reg - ONE_C);
                                state_next = S_FETCH;
                            end
                        end
                        ACT_INSERT: begin
                            if (count_reg == DEPTH_C) begin
                                m_status_next = ST_FULL;
                                m_valid_next  = 1'b1;
                            end else if (s_position > count_reg) begin
                                m_status_next = ST_BADPOS;
                                m_valid_next  = 1'b1;
                            end else begin
                                idx_next   = count_reg;
                                state_next = S_SHRD;
                            end
                        end
                        ACT_REMOVE, ACT_READ: begin
                            if (s_position >= count_reg) begin
                                m_status_next = ST_BADPOS;
                                m_valid_next  = 1'b1;
                            end else begin
                                mem_raddr  = s_position[AW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                m_value_next = rd_data_reg;
                if (act_reg == ACT_REMOVE) begin
                    idx_next   = pos_reg;
                    state_next = S_SHRD;
                end else begin
                    if (act_reg == ACT_POP) begin
                        count_next = count_reg - ONE_C;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SHRD: begin
                if (act_reg == ACT_INSERT) begin
                    if (idx_reg > pos_reg) begin
                        mem_raddr  = idx_dec[AW-1:0];
                        state_next = S_SHWR;
                    end else begin
                        // gap is open, drop the new word in
                        mem_we       = 1'b1;
                        mem_waddr    = pos_reg[AW-1:0];
                        mem_wdata    = word_reg;
                        count_next   = count_reg + ONE_C;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    if (idx_inc < count_reg) begin
                        mem_raddr  = idx_inc[AW-1:0];
                        state_next = S_SHWR;
                    end else begin
                        count_next   = count_reg - ONE_C;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_SHWR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = (act_reg == ACT_INSERT) ? idx_dec : idx_inc;
                state_next = S_SHRD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        act_reg      <= act_next;
        word_reg     <= word_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("fill count above depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_action == ACT_PUSH) && (count_reg != DEPTH_C)
        |=> count_reg == $past(count_reg) + ONE_C)
        else $error("push did not advance the count");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) && !s_fire |=> state_reg == S_IDLE)
        else $error("sequencer left idle without a beat");

    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == S_IDLE)
        else $error("result shown while sequence still running");

endmodule
